### hdl/xpra_pkg.sv
// Package for the XOR PIR reply accumulator: sizes, command codes,
// controller states and the command/status structs between controller
// and datapath. No dependencies.
`default_nettype none

package xpra_pkg;

   localparam int NUM_QUERIES = 8;
   localparam int ROW_WORDS   = 256;
   localparam int WORD_W      = 64;
   localparam int SEL_W       = 8;
   localparam int WIDX_W      = 8;
   localparam int LANE_W      = 3;
   localparam int CODE_W      = 2;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 64;

   typedef enum logic [CODE_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_READ  = 2'd2
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic              wr_clear;
      logic              wr_accum;
      logic              sweep;
      logic [WIDX_W-1:0] sweep_addr;
      logic              out_load;
      logic              out_done;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

### hdl/xpra_ctrl.sv
// Controller of the XOR PIR reply accumulator: clearing sweep after reset,
// request sequencing (fetch, execute) and result hand-off.
// Depends on xpra_pkg.
`default_nettype none

module xpra_ctrl
   import xpra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [CODE_W-1:0] req_code,
   input  wire logic              req_last,
   input  wire dp_sts_type        sts,
   output      dp_cmd_type        cmd
);

   localparam logic [WIDX_W-1:0] SWEEP_LAST = WIDX_W'(ROW_WORDS - 1);

   state_type         state_ff, state_in;
   logic [WIDX_W-1:0] cnt_ff, cnt_in;
   cmd_code_type      code_ff, code_in;
   logic              last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      code_ff <= code_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      code_in    = code_ff;
      last_in    = last_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.wr_clear   = 1'b1;
            cmd.sweep      = 1'b1;
            cmd.sweep_addr = cnt_ff;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               code_in  = cmd_code_type'(req_code);
               last_in  = req_last;
               if (cmd_code_type'(req_code) == CMD_CLEAR ||
                   cmd_code_type'(req_code) == CMD_ACCUM ||
                   cmd_code_type'(req_code) == CMD_READ) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (code_ff)
               CMD_CLEAR: begin
                  cmd.wr_clear = 1'b1;
                  state_in     = ST_IDLE;
               end
               CMD_ACCUM: begin
                  // hold the whole update until the done result can be taken
                  if (!(last_ff && sts.out_busy)) begin
                     cmd.wr_accum = 1'b1;
                     cmd.out_load = last_ff;
                     cmd.out_done = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               CMD_READ: begin
                  if (!sts.out_busy) begin
                     cmd.out_load = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_busy)
      else $error("result loaded while output register is held");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_clear && cmd.wr_accum))
      else $error("clear and accumulate write in the same cycle");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && cnt_ff == SWEEP_LAST) |=> state_ff == ST_IDLE)
      else $error("clearing sweep did not end after the last row");

   a_fetch_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> state_ff == ST_EXEC)
      else $error("memory fetch not followed by execute");
`endif

endmodule

`default_nettype wire

### hdl/xpra_dp.sv
// Datapath of the XOR PIR reply accumulator: request registers, per-lane
// reply memories with registered read, XOR update and result register.
// Depends on xpra_pkg.
`default_nettype none

module xpra_dp
   import xpra_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire dp_cmd_type            cmd,
   output      dp_sts_type            sts,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tuser
);

   logic [WORD_W-1:0] lane_mem [NUM_QUERIES][ROW_WORDS];
   logic [WORD_W-1:0] rd_ff    [NUM_QUERIES];

   logic [WORD_W-1:0] word_ff;
   logic [SEL_W-1:0]  sel_ff;
   logic [WIDX_W-1:0] widx_ff;
   logic [LANE_W-1:0] lane_ff;

   logic [WIDX_W-1:0] wr_addr;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_tdata[WORD_W-1:0];
         sel_ff  <= req_tdata[WORD_W+SEL_W-1:WORD_W];
         widx_ff <= req_tdata[WORD_W+SEL_W+WIDX_W-1:WORD_W+SEL_W];
         lane_ff <= req_tdata[WORD_W+SEL_W+WIDX_W+LANE_W-1:WORD_W+SEL_W+WIDX_W];
      end
   end

   assign wr_addr = cmd.sweep ? cmd.sweep_addr : widx_ff;

   always_ff @(posedge clock) begin
      for (int q = 0; q < NUM_QUERIES; q++) begin
         if (cmd.wr_clear) begin
            lane_mem[q][wr_addr] <= '0;
         end else if (cmd.wr_accum && sel_ff[q]) begin
            lane_mem[q][wr_addr] <= rd_ff[q] ^ word_ff;
         end
         if (cmd.rd_en) begin
            rd_ff[q] <= lane_mem[q][widx_ff];
         end
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_word_ff <= cmd.out_done ? '0 : rd_ff[lane_ff];
         rsp_done_ff <= cmd.out_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTHESIS
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata == '0)
      else $error("done result carries nonzero data");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      ($past(sts.out_busy) && !$past(cmd.out_load)) |-> $stable(rsp_tdata))
      else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

### hdl/xor_pir_reply_accumulator_top.sv
// XOR PIR reply accumulator, top level: joins the controller and the
// datapath. Depends on xpra_pkg, xpra_ctrl and xpra_dp.
//
// After reset the block zeroes its reply memories, one word index (all 8
// lanes) per cycle, holding req_tready low meanwhile. Each request then
// passes through accept, read of the per-lane reply memories (registered
// read port), and execute, where an accumulate writes back word ^ data into
// every selected lane, a clear writes zero to all lanes and a read or a
// last-marked accumulate loads the result register. A result waits in that
// register while the next request is taken; execute stalls only when a new
// result meets a result that is still held. Command 3 is dropped.
`default_nettype none

module xor_pir_reply_accumulator_top
   import xpra_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // db_word[63:0], select_bits[71:64], word_index[79:72],
   // query_index[82:80], zero pad[87:83]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  wire logic [CODE_W-1:0]     req_tuser,
   input  wire logic                  req_tlast,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // reply_word[63:0]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // is_done[0]
   output      logic                  rsp_tuser
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   xpra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_code   (req_tuser),
      .req_last   (req_tlast),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   xpra_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (dp_cmd),
      .sts        (dp_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
